### rtl/bpa_pkg.sv
// Shared constants, types and helper functions for the buddy page allocator.
package bpa_pkg;

    localparam int POOL_PAGES  = 4096;
    localparam int ORDER_COUNT = 16;
    localparam int PAGE_W      = 12;
    localparam int LINK_W      = 13;
    localparam int ORD_W       = 4;
    localparam int RORD_W      = 5;
    localparam int COUNT_W     = 16;
    localparam int TOTAL_W     = 13;
    localparam int META_W      = ORD_W + 1;

    localparam logic [LINK_W-1:0]  NO_LINK   = LINK_W'(POOL_PAGES);
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    // Action codes carried in the input tuser.
    localparam logic [1:0] ACT_INIT  = 2'd0;
    localparam logic [1:0] ACT_ALLOC = 2'd1;
    localparam logic [1:0] ACT_FREE  = 2'd2;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SEED,
        ST_PUSH0,
        ST_PUSH1,
        ST_UNL0,
        ST_UNL1,
        ST_ACHK,
        ST_ASCAN,
        ST_ASPLIT,
        ST_FRD,
        ST_FCHK,
        ST_FMRG,
        ST_FBUD,
        ST_DONE
    } ctrl_state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD,
        OP_SEED,
        OP_PUSH0,
        OP_PUSH1,
        OP_UNL0,
        OP_UNL1,
        OP_ASTART,
        OP_ORD_INC,
        OP_ATAKE,
        OP_SPLIT_PUSH,
        OP_ORD_DEC,
        OP_AFIN,
        OP_FRD,
        OP_FSTART,
        OP_BRD,
        OP_FUNL,
        OP_FPUSH,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic seed_more;
        logic alloc_bad;
        logic ord_top;
        logic cnt_zero;
        logic head_ok;
        logic split_more;
        logic upper_ok;
        logic free_bad;
        logic mark_set;
        logic merge_stop;
        logic bud_match;
    } dp_status_t;

    // Smallest order whose block holds n pages, capped at ORDER_COUNT.
    function automatic logic [RORD_W-1:0] round_order(input logic [COUNT_W-1:0] n);
        logic [COUNT_W-1:0] m;
        logic [RORD_W-1:0]  r;
        m = n - COUNT_W'(1);
        r = '0;
        if (n > COUNT_W'(1)) begin
            for (int i = 0; i < COUNT_W; i++) begin
                if (m[i]) r = RORD_W'(i + 1);
            end
        end
        return r;
    endfunction

    // Largest order whose block still fits in rem pages.
    function automatic logic [ORD_W-1:0] seed_order(input logic [TOTAL_W-1:0] rem);
        logic [ORD_W-1:0] r;
        r = '0;
        for (int i = 0; i < TOTAL_W; i++) begin
            if (rem[i]) r = ORD_W'(i);
        end
        return r;
    endfunction

endpackage

### rtl/bpa_ctrl.sv
// Controller state machine that sequences init, allocate and free operations.
module bpa_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    input  logic [1:0]         s_action,
    input  logic               m_tready,
    input  bpa_pkg::dp_status_t st,
    output bpa_pkg::dp_cmd_t   cmd,
    output logic               s_tready,
    output logic               m_tvalid
);
    import bpa_pkg::*;

    ctrl_state_t state_reg, state_next;
    ctrl_state_t ret_reg, ret_next;
    logic        seed_reg, seed_next;
    logic        m_valid_reg, m_valid_next;

    // State, return point and output valid registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            ret_reg     <= ST_IDLE;
            seed_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            seed_reg    <= seed_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        state_next   = state_reg;
        ret_next     = ret_reg;
        seed_next    = seed_reg;
        m_valid_next = m_valid_reg && !m_tready;
        cmd.op       = OP_NONE;
        s_tready     = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.op = OP_CLEAR;
                if (st.clr_last) begin
                    state_next = seed_reg ? ST_SEED : ST_IDLE;
                    seed_next  = 1'b0;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.op = OP_LOAD;
                    case (s_action)
                        ACT_INIT: begin
                            seed_next  = 1'b1;
                            state_next = ST_CLEAR;
                        end
                        ACT_ALLOC: state_next = ST_ACHK;
                        ACT_FREE:  state_next = ST_FRD;
                        default:   state_next = ST_DONE;
                    endcase
                end
            end
            ST_SEED: begin
                if (st.seed_more) begin
                    cmd.op     = OP_SEED;
                    ret_next   = ST_SEED;
                    state_next = ST_PUSH0;
                end else begin
                    cmd.op     = OP_FPUSH;
                    state_next = ST_DONE;
                end
            end
            ST_PUSH0: begin
                cmd.op     = OP_PUSH0;
                state_next = ST_PUSH1;
            end
            ST_PUSH1: begin
                cmd.op     = OP_PUSH1;
                state_next = ret_reg;
            end
            ST_UNL0: begin
                cmd.op     = OP_UNL0;
                state_next = ST_UNL1;
            end
            ST_UNL1: begin
                cmd.op     = OP_UNL1;
                state_next = ret_reg;
            end
            ST_ACHK: begin
                if (st.alloc_bad) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.op     = OP_ASTART;
                    state_next = ST_ASCAN;
                end
            end
            ST_ASCAN: begin
                if (st.ord_top) begin
                    state_next = ST_DONE;
                end else if (st.cnt_zero) begin
                    cmd.op = OP_ORD_INC;
                end else if (!st.head_ok) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.op     = OP_ATAKE;
                    ret_next   = ST_ASPLIT;
                    state_next = ST_UNL0;
                end
            end
            ST_ASPLIT: begin
                if (st.split_more) begin
                    if (st.upper_ok) begin
                        cmd.op     = OP_SPLIT_PUSH;
                        ret_next   = ST_ASPLIT;
                        state_next = ST_PUSH0;
                    end else begin
                        cmd.op = OP_ORD_DEC;
                    end
                end else begin
                    cmd.op     = OP_AFIN;
                    state_next = ST_DONE;
                end
            end
            ST_FRD: begin
                if (st.free_bad) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.op     = OP_FRD;
                    state_next = ST_FCHK;
                end
            end
            ST_FCHK: begin
                if (st.mark_set) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.op     = OP_FSTART;
                    state_next = ST_FMRG;
                end
            end
            ST_FMRG: begin
                if (st.merge_stop) begin
                    cmd.op     = OP_FPUSH;
                    ret_next   = ST_DONE;
                    state_next = ST_PUSH0;
                end else begin
                    cmd.op     = OP_BRD;
                    state_next = ST_FBUD;
                end
            end
            ST_FBUD: begin
                if (st.bud_match) begin
                    cmd.op     = OP_FUNL;
                    ret_next   = ST_FMRG;
                    state_next = ST_UNL0;
                end else begin
                    cmd.op     = OP_FPUSH;
                    ret_next   = ST_DONE;
                    state_next = ST_PUSH0;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    cmd.op       = OP_EMIT;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_tvalid = m_valid_reg;

endmodule

### rtl/bpa_dp.sv
// Datapath with the block memories, free lists, counters and result registers.
module bpa_dp (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  bpa_pkg::dp_cmd_t             cmd,
    input  logic [1:0]                   s_action,
    input  logic [bpa_pkg::COUNT_W-1:0]  s_count,
    input  logic [bpa_pkg::PAGE_W-1:0]   s_offset,
    input  logic                         cfg_valid,
    input  logic [bpa_pkg::TOTAL_W-1:0]  cfg_data,
    output bpa_pkg::dp_status_t          st,
    output logic                         out_ok,
    output logic [bpa_pkg::PAGE_W-1:0]   out_where,
    output logic [bpa_pkg::TOTAL_W-1:0]  out_free
);
    import bpa_pkg::*;

    // Per-page memories: free mark with order, and list links.
    logic [META_W-1:0] meta_mem [POOL_PAGES];
    logic [LINK_W-1:0] next_mem [POOL_PAGES];
    logic [LINK_W-1:0] prev_mem [POOL_PAGES];

    logic [META_W-1:0] meta_rd_reg;
    logic [LINK_W-1:0] nxt_rd_reg;
    logic [LINK_W-1:0] prv_rd_reg;

    logic [LINK_W-1:0]  heads_reg [ORDER_COUNT];
    logic [LINK_W-1:0]  heads_next [ORDER_COUNT];
    logic [TOTAL_W-1:0] counts_reg [ORDER_COUNT];
    logic [TOTAL_W-1:0] counts_next [ORDER_COUNT];

    logic [TOTAL_W-1:0] free_total_reg, free_total_next;
    logic [TOTAL_W-1:0] total_pages_reg, total_pages_next;
    logic [PAGE_W-1:0]  clr_reg, clr_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic [PAGE_W-1:0]  off_reg, off_next;
    logic [RORD_W-1:0]  best_reg, best_next;
    logic [RORD_W-1:0]  ord_reg, ord_next;
    logic [PAGE_W-1:0]  blk_reg, blk_next;
    logic [ORD_W-1:0]   tgt_ord_reg, tgt_ord_next;
    logic [PAGE_W-1:0]  tgt_idx_reg, tgt_idx_next;
    logic [TOTAL_W-1:0] pos_reg, pos_next;
    logic [TOTAL_W-1:0] lim_reg, lim_next;
    logic               res_ok_reg, res_ok_next;
    logic [PAGE_W-1:0]  res_where_reg, res_where_next;
    logic               out_ok_reg, out_ok_next;
    logic [PAGE_W-1:0]  out_where_reg, out_where_next;
    logic [TOTAL_W-1:0] out_free_reg, out_free_next;

    // Memory write and read controls.
    logic              meta_we;
    logic [PAGE_W-1:0] meta_wa;
    logic [META_W-1:0] meta_wd;
    logic [PAGE_W-1:0] meta_ra;
    logic              next_we;
    logic [PAGE_W-1:0] next_wa;
    logic [LINK_W-1:0] next_wd;
    logic              prev_we;
    logic [PAGE_W-1:0] prev_wa;
    logic [LINK_W-1:0] prev_wd;

    // Derived values.
    logic [LINK_W-1:0]  cur_head;
    logic [TOTAL_W-1:0] cur_count;
    logic [ORD_W-1:0]   ord_m1;
    logic [PAGE_W+4:0]  upper;
    logic [COUNT_W-1:0] bud;
    logic [ORD_W-1:0]   sd_ord;
    logic [TOTAL_W:0]   free_sum;

    assign cur_head  = heads_reg[tgt_ord_reg];
    assign cur_count = counts_reg[tgt_ord_reg];
    assign ord_m1    = ORD_W'(ord_reg - RORD_W'(1));
    assign upper     = (PAGE_W+5)'(blk_reg) + ((PAGE_W+5)'(1) << ord_m1);
    assign bud       = COUNT_W'(blk_reg) ^ (COUNT_W'(1) << ord_reg[ORD_W-1:0]);
    assign sd_ord    = seed_order(lim_reg - pos_reg);

    // Status flags for the controller.
    always_comb begin
        st.clr_last   = (clr_reg == {PAGE_W{1'b1}});
        st.seed_more  = (pos_reg < lim_reg);
        st.alloc_bad  = (cnt_reg == '0) || (cnt_reg > COUNT_W'(free_total_reg)) ||
                        (best_reg >= RORD_W'(ORDER_COUNT));
        st.ord_top    = (ord_reg >= RORD_W'(ORDER_COUNT));
        st.cnt_zero   = (cur_count == '0);
        st.head_ok    = (cur_head < NO_LINK);
        st.split_more = (ord_reg > best_reg);
        st.upper_ok   = (upper < (PAGE_W+5)'(POOL_PAGES));
        st.free_bad   = (best_reg >= RORD_W'(ORDER_COUNT)) ||
                        ((PAGE_W+5)'(off_reg) + ((PAGE_W+5)'(1) << best_reg[ORD_W-1:0])
                         > (PAGE_W+5)'(POOL_PAGES));
        st.mark_set   = meta_rd_reg[META_W-1];
        st.merge_stop = (ord_reg >= RORD_W'(ORDER_COUNT-1)) ||
                        (bud >= COUNT_W'(POOL_PAGES));
        st.bud_match  = meta_rd_reg[META_W-1] &&
                        (meta_rd_reg[ORD_W-1:0] == ord_reg[ORD_W-1:0]);
    end

    // Next-state logic for the datapath registers and memory writes.
    always_comb begin
        heads_next       = heads_reg;
        counts_next      = counts_reg;
        free_total_next  = free_total_reg;
        total_pages_next = cfg_valid ? cfg_data : total_pages_reg;
        clr_next         = clr_reg;
        cnt_next         = cnt_reg;
        off_next         = off_reg;
        best_next        = best_reg;
        ord_next         = ord_reg;
        blk_next         = blk_reg;
        tgt_ord_next     = tgt_ord_reg;
        tgt_idx_next     = tgt_idx_reg;
        pos_next         = pos_reg;
        lim_next         = lim_reg;
        res_ok_next      = res_ok_reg;
        res_where_next   = res_where_reg;
        out_ok_next      = out_ok_reg;
        out_where_next   = out_where_reg;
        out_free_next    = out_free_reg;
        free_sum         = '0;
        meta_we          = 1'b0;
        meta_wa          = tgt_idx_reg;
        meta_wd          = '0;
        meta_ra          = off_reg;
        next_we          = 1'b0;
        next_wa          = tgt_idx_reg;
        next_wd          = '0;
        prev_we          = 1'b0;
        prev_wa          = tgt_idx_reg;
        prev_wd          = '0;
        case (cmd.op)
            OP_CLEAR: begin
                meta_we  = 1'b1;
                meta_wa  = clr_reg;
                meta_wd  = '0;
                clr_next = clr_reg + PAGE_W'(1);
            end
            OP_LOAD: begin
                cnt_next       = s_count;
                off_next       = s_offset;
                best_next      = round_order(s_count);
                res_ok_next    = 1'b0;
                res_where_next = '0;
                if (s_action == ACT_INIT) begin
                    for (int i = 0; i < ORDER_COUNT; i++) begin
                        heads_next[i]  = NO_LINK;
                        counts_next[i] = '0;
                    end
                    free_total_next = '0;
                    clr_next        = '0;
                    pos_next        = '0;
                    lim_next        = (total_pages_reg > TOTAL_W'(POOL_PAGES)) ?
                                      TOTAL_W'(POOL_PAGES) : total_pages_reg;
                end
            end
            OP_SEED: begin
                tgt_ord_next = sd_ord;
                tgt_idx_next = pos_reg[PAGE_W-1:0];
                pos_next     = pos_reg + (TOTAL_W'(1) << sd_ord);
                free_sum     = (TOTAL_W+1)'(free_total_reg) + ((TOTAL_W+1)'(1) << sd_ord);
                free_total_next = (free_sum > (TOTAL_W+1)'(TOTAL_MAX)) ?
                                  TOTAL_MAX : free_sum[TOTAL_W-1:0];
            end
            OP_PUSH0: begin
                next_we = 1'b1;
                next_wd = cur_head;
                prev_we = 1'b1;
                prev_wd = NO_LINK;
                meta_we = 1'b1;
                meta_wd = {1'b1, tgt_ord_reg};
            end
            OP_PUSH1: begin
                if (cur_head < NO_LINK) begin
                    prev_we = 1'b1;
                    prev_wa = cur_head[PAGE_W-1:0];
                    prev_wd = LINK_W'(tgt_idx_reg);
                end
                heads_next[tgt_ord_reg]  = LINK_W'(tgt_idx_reg);
                counts_next[tgt_ord_reg] = cur_count + TOTAL_W'(1);
            end
            OP_UNL1: begin
                if (prv_rd_reg < NO_LINK) begin
                    next_we = 1'b1;
                    next_wa = prv_rd_reg[PAGE_W-1:0];
                    next_wd = nxt_rd_reg;
                end else begin
                    heads_next[tgt_ord_reg] = nxt_rd_reg;
                end
                if (nxt_rd_reg < NO_LINK) begin
                    prev_we = 1'b1;
                    prev_wa = nxt_rd_reg[PAGE_W-1:0];
                    prev_wd = prv_rd_reg;
                end
                if (cur_count != '0) begin
                    counts_next[tgt_ord_reg] = cur_count - TOTAL_W'(1);
                end
                meta_we = 1'b1;
                meta_wd = {1'b0, tgt_ord_reg};
            end
            OP_ASTART: begin
                ord_next     = best_reg;
                tgt_ord_next = best_reg[ORD_W-1:0];
            end
            OP_ORD_INC: begin
                ord_next     = ord_reg + RORD_W'(1);
                tgt_ord_next = tgt_ord_reg + ORD_W'(1);
            end
            OP_ATAKE: begin
                blk_next     = cur_head[PAGE_W-1:0];
                tgt_idx_next = cur_head[PAGE_W-1:0];
            end
            OP_SPLIT_PUSH: begin
                ord_next     = ord_reg - RORD_W'(1);
                tgt_ord_next = ord_m1;
                tgt_idx_next = upper[PAGE_W-1:0];
            end
            OP_ORD_DEC: begin
                ord_next = ord_reg - RORD_W'(1);
            end
            OP_AFIN: begin
                free_total_next = free_total_reg - (TOTAL_W'(1) << best_reg[ORD_W-1:0]);
                res_ok_next     = 1'b1;
                res_where_next  = blk_reg;
            end
            OP_FRD: begin
                meta_ra = off_reg;
            end
            OP_FSTART: begin
                blk_next = off_reg;
                ord_next = best_reg;
                free_sum = (TOTAL_W+1)'(free_total_reg) +
                           ((TOTAL_W+1)'(1) << best_reg[ORD_W-1:0]);
                free_total_next = (free_sum > (TOTAL_W+1)'(TOTAL_MAX)) ?
                                  TOTAL_MAX : free_sum[TOTAL_W-1:0];
            end
            OP_BRD: begin
                meta_ra = bud[PAGE_W-1:0];
            end
            OP_FUNL: begin
                tgt_idx_next = bud[PAGE_W-1:0];
                tgt_ord_next = ord_reg[ORD_W-1:0];
                if (bud[PAGE_W-1:0] < blk_reg) begin
                    blk_next = bud[PAGE_W-1:0];
                end
                ord_next = ord_reg + RORD_W'(1);
            end
            OP_FPUSH: begin
                tgt_ord_next = ord_reg[ORD_W-1:0];
                tgt_idx_next = blk_reg;
                res_ok_next  = 1'b1;
            end
            OP_EMIT: begin
                out_ok_next    = res_ok_reg;
                out_where_next = res_where_reg;
                out_free_next  = free_total_reg;
            end
            default: begin
            end
        endcase
    end

    // Datapath registers; list state, totals and sweep pointer are reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ORDER_COUNT; i++) begin
                heads_reg[i]  <= NO_LINK;
                counts_reg[i] <= '0;
            end
            free_total_reg  <= '0;
            total_pages_reg <= TOTAL_W'(POOL_PAGES);
            clr_reg         <= '0;
        end else begin
            heads_reg       <= heads_next;
            counts_reg      <= counts_next;
            free_total_reg  <= free_total_next;
            total_pages_reg <= total_pages_next;
            clr_reg         <= clr_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg       <= cnt_next;
        off_reg       <= off_next;
        best_reg      <= best_next;
        ord_reg       <= ord_next;
        blk_reg       <= blk_next;
        tgt_ord_reg   <= tgt_ord_next;
        tgt_idx_reg   <= tgt_idx_next;
        pos_reg       <= pos_next;
        lim_reg       <= lim_next;
        res_ok_reg    <= res_ok_next;
        res_where_reg <= res_where_next;
        out_ok_reg    <= out_ok_next;
        out_where_reg <= out_where_next;
        out_free_reg  <= out_free_next;
    end

    // Mark and order memory.
    always_ff @(posedge aclk) begin
        if (meta_we) meta_mem[meta_wa] <= meta_wd;
        meta_rd_reg <= meta_mem[meta_ra];
    end

    // Forward link memory.
    always_ff @(posedge aclk) begin
        if (next_we) next_mem[next_wa] <= next_wd;
        nxt_rd_reg <= next_mem[tgt_idx_reg];
    end

    // Backward link memory.
    always_ff @(posedge aclk) begin
        if (prev_we) prev_mem[prev_wa] <= prev_wd;
        prv_rd_reg <= prev_mem[tgt_idx_reg];
    end

    assign out_ok    = out_ok_reg;
    assign out_where = out_where_reg;
    assign out_free  = out_free_reg;

endmodule

### rtl/buddy_page_allocator_top.sv
// Top level of the buddy page allocator: stream ports, controller and datapath.
//
//  Channel   Direction  Handshake              Contents
//  s_        in         s_tvalid / s_tready    tuser: action; tdata: page_count, block_offset
//  m_        out        m_tvalid / m_tready    tuser: ok; tdata: alloc_offset, free_total
//  cfg_      in         cfg_valid / cfg_ready  data: total_pages
//
// One item is in work at a time. A successful alloc scans up past empty orders, unlinks
// the block and pushes each upper half inside the pool as it splits; a free reads the
// mark, then each buddy, unlinking it on a match, and pushes the merged block. Init
// sweeps the 4096-entry mark memory one entry a cycle, then seeds the pool block by
// block; after reset the same sweep runs before the first transaction is taken. A result
// waits in an output register, and a stalled m_tready holds the finished item until taken.
module buddy_page_allocator_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] page_count, [27:16] block_offset
    input  logic [1:0]  s_tuser,   // [1:0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [11:0] alloc_offset, [24:12] free_total
    output logic [0:0]  m_tuser,   // [0] ok
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [12:0] cfg_data
);
    import bpa_pkg::*;

    dp_cmd_t            cmd;
    dp_status_t         st;
    logic               out_ok;
    logic [PAGE_W-1:0]  out_where;
    logic [TOTAL_W-1:0] out_free;

    assign cfg_ready = 1'b1;

    bpa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_action (s_tuser),
        .m_tready (m_tready),
        .st       (st),
        .cmd      (cmd),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid)
    );

    bpa_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .s_action  (s_tuser),
        .s_count   (s_tdata[COUNT_W-1:0]),
        .s_offset  (s_tdata[COUNT_W+PAGE_W-1:COUNT_W]),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .st        (st),
        .out_ok    (out_ok),
        .out_where (out_where),
        .out_free  (out_free)
    );

    assign m_tdata = {7'd0, out_free, out_where};
    assign m_tuser = out_ok;

    // The block takes no new transaction right after accepting one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted on two consecutive cycles");

    // A failed or non-allocating result reports a zero offset.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[PAGE_W-1:0] == '0)
        else $error("failed result carries a nonzero offset");

    // The clearing sweep keeps the input closed right after reset.
    assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("input ready during the clearing sweep");

    // m_tvalid does not rise right after a new transaction is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result appeared in the cycle after an accept");

endmodule

### dv/tb_top.sv
// Self-checking testbench for the buddy page allocator with its own allocator model.
`timescale 1ns / 100ps

module tb_top;
    import bpa_pkg::*;

    typedef struct {
        logic [1:0]  action;
        logic [15:0] page_count;
        logic [11:0] block_offset;
    } page_req_t;

    typedef struct {
        logic        ok;
        logic [11:0] alloc_offset;
        logic [12:0] free_total;
    } page_rsp_t;

    typedef struct {
        int offset;
        int order;
    } live_blk_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [12:0] cfg_data;

    // Allocator model state.
    bit          blk_mark [POOL_PAGES];
    int          blk_order [POOL_PAGES];
    int          blk_next [POOL_PAGES];
    int          blk_prev [POOL_PAGES];
    int          order_head [ORDER_COUNT];
    int          order_len [ORDER_COUNT];
    int          pages_free;
    int          pool_size;

    page_req_t   req_q[$];
    page_rsp_t   rsp_q[$];
    live_blk_t   live_q[$];
    bit          req_taken;
    bit          calm;
    bit          failed;

    buddy_page_allocator_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Clock generation.
    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Push a block onto the head of its order list.
    task automatic push_blk(input int ord, input int idx);
        int h;
        h = order_head[ord];
        blk_prev[idx] = POOL_PAGES;
        blk_next[idx] = h;
        if (h < POOL_PAGES) blk_prev[h] = idx;
        order_head[ord] = idx;
        order_len[ord]++;
        blk_order[idx] = ord;
        blk_mark[idx] = 1'b1;
    endtask

    // Remove a block from anywhere in its order list.
    task automatic unlink_blk(input int ord, input int idx);
        int p;
        int n;
        p = blk_prev[idx];
        n = blk_next[idx];
        if (p < POOL_PAGES) blk_next[p] = n;
        else order_head[ord] = n;
        if (n < POOL_PAGES) blk_prev[n] = p;
        if (order_len[ord] > 0) order_len[ord]--;
        blk_mark[idx] = 1'b0;
    endtask

    task automatic wipe_pool();
        for (int i = 0; i < POOL_PAGES; i++) begin
            blk_mark[i] = 1'b0;
            blk_order[i] = 0;
            blk_next[i] = 0;
            blk_prev[i] = 0;
        end
        for (int i = 0; i < ORDER_COUNT; i++) begin
            order_head[i] = POOL_PAGES;
            order_len[i] = 0;
        end
        pages_free = 0;
    endtask

    function automatic int order_for(input int n);
        int ord;
        int size;
        ord = 0;
        size = 1;
        while (size < n && ord < ORDER_COUNT) begin
            ord++;
            size = size * 2;
        end
        return ord;
    endfunction

    // Apply one transaction to the model and return the expected response.
    task automatic predict_page_op(input page_req_t rq, output page_rsp_t rs);
        int n, pos, rem, ord, size, best, blk, cur, bud;
        rs.ok = 1'b0;
        rs.alloc_offset = '0;
        if (rq.action == ACT_INIT) begin
            wipe_pool();
            live_q.delete();
            n = (pool_size > POOL_PAGES) ? POOL_PAGES : pool_size;
            pos = 0;
            while (pos < n) begin
                rem = n - pos;
                ord = 0;
                size = 1;
                while (size * 2 <= rem && ord < ORDER_COUNT - 1) begin
                    ord++;
                    size = size * 2;
                end
                push_blk(ord, pos);
                pages_free += size;
                if (pages_free > 8191) pages_free = 8191;
                pos += size;
            end
            rs.ok = 1'b1;
        end else if (rq.action == ACT_ALLOC) begin
            n = rq.page_count;
            best = order_for(n);
            if (n != 0 && n <= pages_free && best < ORDER_COUNT) begin
                ord = best;
                while (ord < ORDER_COUNT && order_len[ord] == 0) ord++;
                if (ord < ORDER_COUNT && order_head[ord] < POOL_PAGES) begin
                    blk = order_head[ord];
                    unlink_blk(ord, blk);
                    // Split down, returning each upper half that lies inside the pool to the list below.
                    while (ord > best) begin
                        ord--;
                        if (blk + (1 << ord) < POOL_PAGES) push_blk(ord, blk + (1 << ord));
                    end
                    blk_order[blk] = best;
                    pages_free -= (1 << best);
                    rs.ok = 1'b1;
                    rs.alloc_offset = blk[11:0];
                    live_q.push_back('{blk, best});
                end
            end
        end else if (rq.action == ACT_FREE) begin
            ord = order_for(rq.page_count);
            cur = rq.block_offset;
            if (ord < ORDER_COUNT && cur + (1 << ord) <= POOL_PAGES && !blk_mark[cur]) begin
                pages_free += (1 << ord);
                if (pages_free > 8191) pages_free = 8191;
                // Merge with the buddy while it is a free block of the same order.
                while (ord < ORDER_COUNT - 1) begin
                    bud = cur ^ (1 << ord);
                    if (bud >= POOL_PAGES || !blk_mark[bud] || blk_order[bud] != ord) break;
                    unlink_blk(ord, bud);
                    if (bud < cur) cur = bud;
                    ord++;
                end
                push_blk(ord, cur);
                rs.ok = 1'b1;
            end
        end
        rs.free_total = pages_free[12:0];
    endtask

    // Input driver: presents queued requests with random gaps and drives a random m_tready.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end else begin
            if (!s_tvalid || req_taken) begin
                if (req_q.size() != 0 && (calm || $urandom_range(0, 99) >= 26)) begin
                    s_tvalid <= 1'b1;
                    s_tuser  <= req_q[0].action;
                    s_tdata  <= {4'b0, req_q[0].block_offset, req_q[0].page_count};
                    void'(req_q.pop_front());
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= calm || ($urandom_range(0, 99) >= 26);
        end
    end

    // Monitor: predicts accepted requests and checks responses.
    always @(posedge aclk) begin
        page_req_t rq;
        page_rsp_t rs;
        req_taken <= s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            rq.action = s_tuser;
            rq.page_count = s_tdata[15:0];
            rq.block_offset = s_tdata[27:16];
            predict_page_op(rq, rs);
            rsp_q.push_back(rs);
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (rsp_q.size() == 0) begin
                $display("%0t: unexpected response tuser=%h tdata=%h", $time, m_tuser, m_tdata);
                failed = 1'b1;
            end else begin
                rs = rsp_q.pop_front();
                if (m_tuser[0] !== rs.ok) begin
                    $display("%0t: ok expected %0d actual %0d", $time, rs.ok, m_tuser[0]);
                    failed = 1'b1;
                end
                if (m_tdata[11:0] !== rs.alloc_offset) begin
                    $display("%0t: alloc_offset expected %0d actual %0d",
                             $time, rs.alloc_offset, m_tdata[11:0]);
                    failed = 1'b1;
                end
                if (m_tdata[24:12] !== rs.free_total) begin
                    $display("%0t: free total expected %0d actual %0d",
                             $time, rs.free_total, m_tdata[24:12]);
                    failed = 1'b1;
                end
            end
        end
    end

    task automatic add_req(input logic [1:0] act, input int cnt, input int off);
        page_req_t rq;
        rq.action = act;
        rq.page_count = cnt[15:0];
        rq.block_offset = off[11:0];
        req_q.push_back(rq);
    endtask

    // Build one random request; most frees return one of the current live allocations.
    task automatic add_random_req();
        int r, k, o, cnt;
        live_blk_t lb;
        r = $urandom_range(0, 99);
        if (r < 1) begin
            add_req(ACT_INIT, $urandom, $urandom);
        end else if (r < 4) begin
            add_req(2'd3, $urandom, $urandom);
        end else if (r < 48 || (r < 88 && live_q.size() == 0)) begin
            k = $urandom_range(0, 99);
            if (k < 80) cnt = $urandom_range(1, 64);
            else if (k < 95) cnt = $urandom_range(1, 4096);
            else cnt = $urandom_range(0, 65535);
            add_req(ACT_ALLOC, cnt, $urandom);
        end else if (r < 88) begin
            k = $urandom_range(0, live_q.size() - 1);
            lb = live_q[k];
            live_q.delete(k);
            o = lb.order;
            cnt = (o == 0) ? $urandom_range(0, 1) : $urandom_range((1 << (o - 1)) + 1, 1 << o);
            add_req(ACT_FREE, cnt, lb.offset);
        end else begin
            add_req(ACT_FREE, $urandom_range(0, 65535) >> $urandom_range(0, 16),
                    $urandom_range(0, 4095));
        end
    endtask

    task automatic drain();
        while (req_q.size() != 0 || s_tvalid || rsp_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_pool_size(input int val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= val[12:0];
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        pool_size = val & 13'h1FFF;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Stimulus: directed cases, then random phases over several pool sizes.
    initial begin
        int sizes[6];
        int made;
        sizes = '{1, 8191, 0, 4096, 0, 3000};
        sizes[4] = $urandom_range(1, 4096);
        failed = 1'b0;
        calm = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = '0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        req_taken = 1'b0;
        pool_size = 4096;
        wipe_pool();
        aresetn = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: empty pool, extremes, zero counts, rejections, unknown action.
        add_req(ACT_ALLOC, 1, 0);
        add_req(ACT_FREE, 1, 4095);
        add_req(ACT_INIT, 0, 0);
        add_req(ACT_ALLOC, 0, 0);
        add_req(ACT_ALLOC, 65535, 0);
        add_req(ACT_ALLOC, 4096, 0);
        add_req(ACT_ALLOC, 1, 0);
        add_req(ACT_FREE, 4096, 0);
        add_req(ACT_ALLOC, 1, 0);
        add_req(ACT_FREE, 0, 0);
        add_req(ACT_ALLOC, 3, 0);
        add_req(ACT_FREE, 4, 0);
        add_req(ACT_FREE, 1, 0);
        add_req(ACT_FREE, 2, 4095);
        add_req(ACT_FREE, 32768, 0);
        add_req(2'd3, 65535, 4095);
        add_req(ACT_ALLOC, 2048, 0);
        add_req(ACT_ALLOC, 2049, 0);
        add_req(ACT_FREE, 2048, 2048);
        add_req(ACT_FREE, 1, 2048);
        made = 0;
        for (int ph = 0; ph < 7; ph++) begin
            if (ph != 0) begin
                drain();
                write_pool_size(sizes[ph - 1]);
                add_req(ACT_INIT, 0, 0);
            end
            for (int i = 0; i < 135; i++) begin
                while (req_q.size() != 0) @(posedge aclk);
                calm = (made >= 400 && made < 520);
                add_random_req();
                made++;
            end
        end
        drain();
        if (!failed) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #100_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
